// File: src/mpq_pkg.sv
// mpq_pkg: types, constants and codes shared by the ready queue modules
// depends on nothing; used by mpq_ctrl, mpq_dpath and the top level

package mpq_pkg;

	// queue geometry
	localparam int LEVELS      = 140;
	localparam int LEVEL_DEPTH = 8;
	localparam int PRIO_CAP    = 139;

	// field widths fixed by the interface
	localparam int FIELD_W  = 8;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 24;

	// derived widths
	localparam int LVL_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int SLOT_W      = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
	localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);
	localparam int ENTRY_DEPTH = LEVELS * LEVEL_DEPTH;
	localparam int ENTRY_AW    = $clog2(ENTRY_DEPTH);

	// two-stage search over the non-empty map: groups of GRP_SIZE levels
	localparam int GRP_SIZE = 16;
	localparam int GRP_W    = $clog2(GRP_SIZE);
	localparam int NGRP     = (LEVELS + GRP_SIZE - 1) / GRP_SIZE;
	localparam int NGRP_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int MAP_W    = NGRP * GRP_SIZE;

	typedef enum logic {
		REQ_ENQ = 1'b0,
		REQ_DEQ = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_DROP  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ENQ_WR,
		S_DEQ_FIND,
		S_DEQ_META,
		S_DEQ_DATA,
		S_DONE
	} state_t;

	// per level ring bookkeeping
	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [SLOT_W-1:0] head;
	} meta_t;

	// one stored entry
	typedef struct packed {
		logic [FIELD_W-1:0] prio;
		logic [FIELD_W-1:0] pid;
	} entry_t;

	// one result word
	typedef struct packed {
		status_t            status;
		logic [FIELD_W-1:0] level;
		logic [FIELD_W-1:0] prio;
		logic [FIELD_W-1:0] pid;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic enq_commit;
		logic deq_find;
		logic deq_commit;
		logic deq_result;
		logic load_out;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_deq;
		logic in_lvl_ok;
		logic any_ready;
		logic out_free;
	} dp_stat_t;

endpackage

// File: src/multilevel_priority_ready_queue.sv
// multilevel_priority_ready_queue: ready queue with one ring per priority level
// depends on mpq_pkg, mpq_ctrl, mpq_dpath and mpq_ram
//
// Usage: each word on the s_ channel is one request. s_tuser selects enqueue
// or dequeue. An enqueue appends (process_id, entry_prio) to the ring of the
// named level, or is dropped when that ring is full or the level is out of
// range. A dequeue pops the oldest entry of the lowest-numbered non-empty level
// and returns it with its priority aged by one, capped at 139.
// Every request yields exactly one word on the m_ channel, in request order;
// m_tuser carries the status (ok, dropped, empty).
// An enqueue steps through S_ENQ_WR to S_DONE (straight to S_DONE when out of
// range), a dequeue through S_DEQ_FIND, S_DEQ_META, S_DEQ_DATA and S_DONE (from
// S_DEQ_FIND to S_DONE when all levels are empty), set by the registered read of
// the level bookkeeping ram followed by its write, and for a dequeue the two-stage
// search of the non-empty map and the registered read of the entry ram.
// The result sits in an output register; the next request is accepted while
// it waits. When the receiver stalls, one further request is processed and then
// s_tready stays low until the output word is taken.
// Reset clears all levels to empty at once; no clearing pass is needed.

module multilevel_priority_ready_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [mpq_pkg::S_DATA_W-1:0] s_tdata,  // level, process_id, entry_prio
	input  logic                         s_tuser,  // req_type
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [mpq_pkg::M_DATA_W-1:0] m_tdata,  // out_process_id, out_prio, out_level
	output logic [1:0]                   m_tuser   // status
);

	mpq_pkg::ctl_cmd_t cmd;
	mpq_pkg::dp_stat_t stat;

	// sequencer
	mpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_ready  (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// storage and result path
	mpq_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

// File: src/mpq_ram.sv
// mpq_ram: generic simple dual port ram, one write and one registered read port
// depends on nothing

module mpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/mpq_ctrl.sv
// mpq_ctrl: sequencer for enqueue and dequeue requests
// depends on mpq_pkg; drives mpq_dpath through ctl_cmd_t

module mpq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_ready,
	input  mpq_pkg::dp_stat_t stat,
	output mpq_pkg::ctl_cmd_t cmd
);

	mpq_pkg::state_t state_q, state_nxt, start_st;
	logic            accept;

	// input handshake: idle, or done with room in the output register
	assign s_ready = (state_q == mpq_pkg::S_IDLE) ||
	                 (state_q == mpq_pkg::S_DONE && stat.out_free);
	assign accept  = s_tvalid && s_ready;

	// first state for a newly accepted word
	always_comb begin
		if (stat.in_deq) begin
			start_st = mpq_pkg::S_DEQ_FIND;
		end else if (stat.in_lvl_ok) begin
			start_st = mpq_pkg::S_ENQ_WR;
		end else begin
			start_st = mpq_pkg::S_DONE;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mpq_pkg::S_IDLE: begin
				if (accept) state_nxt = start_st;
			end
			mpq_pkg::S_ENQ_WR:   state_nxt = mpq_pkg::S_DONE;
			mpq_pkg::S_DEQ_FIND: begin
				state_nxt = stat.any_ready ? mpq_pkg::S_DEQ_META : mpq_pkg::S_DONE;
			end
			mpq_pkg::S_DEQ_META: state_nxt = mpq_pkg::S_DEQ_DATA;
			mpq_pkg::S_DEQ_DATA: state_nxt = mpq_pkg::S_DONE;
			mpq_pkg::S_DONE: begin
				if (stat.out_free) state_nxt = accept ? start_st : mpq_pkg::S_IDLE;
			end
			default: state_nxt = mpq_pkg::S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd            = '0;
		cmd.accept     = accept;
		unique case (state_q)
			mpq_pkg::S_ENQ_WR:   cmd.enq_commit = 1'b1;
			mpq_pkg::S_DEQ_FIND: cmd.deq_find   = stat.any_ready;
			mpq_pkg::S_DEQ_META: cmd.deq_commit = 1'b1;
			mpq_pkg::S_DEQ_DATA: cmd.deq_result = 1'b1;
			mpq_pkg::S_DONE:     cmd.load_out   = stat.out_free;
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpq_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: src/mpq_dpath.sv
// mpq_dpath: level bookkeeping, entry storage, ready search and output register
// depends on mpq_pkg and mpq_ram; sequenced by mpq_ctrl

module mpq_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mpq_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mpq_pkg::M_DATA_W-1:0]  m_tdata,
	output logic [1:0]                    m_tuser,
	input  mpq_pkg::ctl_cmd_t             cmd,
	output mpq_pkg::dp_stat_t             stat
);

	localparam int LW = mpq_pkg::LVL_W;
	localparam int SW = mpq_pkg::SLOT_W;
	localparam int CW = mpq_pkg::CNT_W;
	localparam int AW = mpq_pkg::ENTRY_AW;
	localparam int FW = mpq_pkg::FIELD_W;

	logic [FW-1:0]               in_level, in_pid, in_prio;
	logic                        in_deq, in_lvl_ok;
	logic [mpq_pkg::LEVELS-1:0]  nonempty_q;
	logic [mpq_pkg::MAP_W-1:0]   map_pad;
	logic [mpq_pkg::NGRP-1:0]    grp_or;
	logic [mpq_pkg::NGRP_W-1:0]  first_grp, grp_q;
	logic                        grp_any_q;
	logic [mpq_pkg::GRP_SIZE-1:0] grp_bits;
	logic [mpq_pkg::GRP_W-1:0]   first_idx;
	logic [LW-1:0]               found_lvl, lvl_q;
	logic [FW-1:0]               pid_q, prio_q;
	mpq_pkg::meta_t              meta_rd, meta_eff, meta_wd;
	logic                        meta_we, meta_re;
	logic [LW-1:0]               meta_raddr;
	logic                        full;
	logic [SW:0]                 slot_sum, head_inc;
	logic [SW-1:0]               tail_slot, head_nxt;
	logic [AW-1:0]               entry_base, entry_waddr, entry_raddr;
	mpq_pkg::entry_t             entry_rd, entry_wd;
	logic                        entry_we;
	logic [FW:0]                 prio_inc;
	logic [FW-1:0]               prio_sat;
	mpq_pkg::result_t            res_q, out_q;
	logic                        out_valid_q, out_free;

	// input word fields
	assign in_level  = s_tdata[7:0];
	assign in_pid    = s_tdata[15:8];
	assign in_prio   = s_tdata[23:16];
	assign in_deq    = (s_tuser == mpq_pkg::REQ_DEQ);
	assign in_lvl_ok = ({1'b0, in_level} < (FW + 1)'(mpq_pkg::LEVELS));

	// first stage of the ready search: lowest non-empty group
	assign map_pad = mpq_pkg::MAP_W'(nonempty_q);

	always_comb begin
		first_grp = '0;
		for (int g = mpq_pkg::NGRP - 1; g >= 0; g--) begin
			grp_or[g] = |map_pad[g*mpq_pkg::GRP_SIZE +: mpq_pkg::GRP_SIZE];
			if (grp_or[g]) first_grp = mpq_pkg::NGRP_W'(g);
		end
	end

	// second stage: lowest non-empty level inside the chosen group
	assign grp_bits = map_pad[grp_q*mpq_pkg::GRP_SIZE +: mpq_pkg::GRP_SIZE];

	always_comb begin
		first_idx = '0;
		for (int i = mpq_pkg::GRP_SIZE - 1; i >= 0; i--) begin
			if (grp_bits[i]) first_idx = mpq_pkg::GRP_W'(i);
		end
	end

	assign found_lvl = LW'({grp_q, first_idx});

	// request capture and search registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			lvl_q  <= in_level[LW-1:0];
			pid_q  <= in_pid;
			prio_q <= in_prio;
			grp_q  <= first_grp;
		end else if (cmd.deq_find) begin
			lvl_q  <= found_lvl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_any_q <= 1'b0;
		end else if (cmd.accept) begin
			grp_any_q <= |grp_or;
		end
	end

	// per level count and head; an empty level reads as count 0, head 0
	assign meta_raddr = cmd.accept ? in_level[LW-1:0] : found_lvl;
	assign meta_re    = (cmd.accept && !in_deq && in_lvl_ok) || cmd.deq_find;
	assign meta_eff   = nonempty_q[lvl_q] ? meta_rd : '0;
	assign full       = (meta_eff.count == CW'(mpq_pkg::LEVEL_DEPTH));

	mpq_ram #(
		.WIDTH ($bits(mpq_pkg::meta_t)),
		.DEPTH (mpq_pkg::LEVELS)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (lvl_q),
		.wdata (meta_wd),
		.re    (meta_re),
		.raddr (meta_raddr),
		.rdata (meta_rd)
	);

	// ring arithmetic
	assign slot_sum  = (SW + 1)'(meta_eff.head) + (SW + 1)'(meta_eff.count);
	assign tail_slot = (slot_sum >= (SW + 1)'(mpq_pkg::LEVEL_DEPTH)) ?
	                   SW'(slot_sum - (SW + 1)'(mpq_pkg::LEVEL_DEPTH)) : SW'(slot_sum);
	assign head_inc  = (SW + 1)'(meta_eff.head) + (SW + 1)'(1);
	assign head_nxt  = (head_inc == (SW + 1)'(mpq_pkg::LEVEL_DEPTH)) ? '0 : SW'(head_inc);

	// meta update
	always_comb begin
		meta_we = 1'b0;
		meta_wd = meta_eff;
		if (cmd.enq_commit && !full) begin
			meta_we       = 1'b1;
			meta_wd.count = meta_eff.count + CW'(1);
		end else if (cmd.deq_commit) begin
			meta_we       = 1'b1;
			meta_wd.count = meta_eff.count - CW'(1);
			meta_wd.head  = head_nxt;
		end
	end

	// non-empty map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q <= '0;
		end else if (cmd.enq_commit && !full) begin
			nonempty_q[lvl_q] <= 1'b1;
		end else if (cmd.deq_commit && meta_eff.count == CW'(1)) begin
			nonempty_q[lvl_q] <= 1'b0;
		end
	end

	// entry storage: level base plus ring slot
	assign entry_base  = AW'(lvl_q) * AW'(mpq_pkg::LEVEL_DEPTH);
	assign entry_waddr = entry_base + AW'(tail_slot);
	assign entry_raddr = entry_base + AW'(meta_eff.head);
	assign entry_we    = cmd.enq_commit && !full;
	assign entry_wd    = '{prio: prio_q, pid: pid_q};

	mpq_ram #(
		.WIDTH ($bits(mpq_pkg::entry_t)),
		.DEPTH (mpq_pkg::ENTRY_DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (entry_we),
		.waddr (entry_waddr),
		.wdata (entry_wd),
		.re    (cmd.deq_commit),
		.raddr (entry_raddr),
		.rdata (entry_rd)
	);

	// aging: priority plus one, capped
	assign prio_inc = {1'b0, entry_rd.prio} + (FW + 1)'(1);
	assign prio_sat = (prio_inc < (FW + 1)'(mpq_pkg::PRIO_CAP)) ?
	                  prio_inc[FW-1:0] : FW'(mpq_pkg::PRIO_CAP);

	// result register; accept presets drop or empty, enqueue commit or dequeue result overrides
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_q.status <= in_deq ? mpq_pkg::STAT_EMPTY : mpq_pkg::STAT_DROP;
			res_q.level  <= '0;
			res_q.prio   <= '0;
			res_q.pid    <= '0;
		end else if (cmd.enq_commit && !full) begin
			res_q.status <= mpq_pkg::STAT_OK;
		end else if (cmd.deq_result) begin
			res_q.status <= mpq_pkg::STAT_OK;
			res_q.pid    <= entry_rd.pid;
			res_q.prio   <= prio_sat;
			res_q.level  <= FW'(lvl_q);
		end
	end

	// output register
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.level, out_q.prio, out_q.pid};
	assign m_tuser  = out_q.status;

	// status to the controller
	assign stat.in_deq    = in_deq;
	assign stat.in_lvl_ok = in_lvl_ok;
	assign stat.any_ready = grp_any_q;
	assign stat.out_free  = out_free;

	// an accepted enqueue marks its level non-empty
	a_enq_marks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq_commit && !full |=> nonempty_q[$past(lvl_q)])
		else $error("enqueue left its level marked empty");

	// a dequeue only pops a level that holds entries
	a_deq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.deq_commit |-> nonempty_q[lvl_q] && meta_eff.count != '0)
		else $error("dequeue from an empty level");

	// a new result never overwrites one still waiting downstream
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !out_valid_q || m_tready)
		else $error("output word overwritten while stalled");

endmodule
